// ----- rtl/core/msh_pkg.sv -----
// ----------------------------------------------------------------------------
// msh_pkg: shared definitions for the multi-seed hash bit signature block
// Hash constants, digit-serial multiplier sizing, register map and the
// sequencer state type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package msh_pkg;

    // MurmurHash64A constants
    localparam logic [63:0] MUL_M   = 64'hc6a4a7935bd1e995;
    localparam int          SHIFT_R = 47;

    // Signature sizing
    localparam int HASH_BITS      = 64;
    localparam int MAX_SEEDS      = 8;
    localparam int MAX_NAME_BYTES = 4095;

    // Remainder by HASH_BITS reduces to a mask for powers of two
    localparam bit HASH_POW2 = ((HASH_BITS & (HASH_BITS - 1)) == 0);

    // Multiplier: one digit of the operand per cycle
    localparam int DIGIT_BITS = 16;
    localparam int NUM_DIGITS = 64 / DIGIT_BITS;
    localparam int DIGIT_CW   = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;

    // Bytes in a full block
    localparam logic [3:0] FULL_BYTES = 4'd8;

    // Register map
    localparam logic [1:0] ADDR_NUM_HASHES  = 2'd0;
    localparam logic [3:0] NUM_HASHES_RESET = 4'd4;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEN,
        ST_K1,
        ST_K2,
        ST_MIX,
        ST_FIN,
        ST_MOD,
        ST_EMIT
    } state_t;

endpackage

`default_nettype wire

// ----- rtl/core/msh_mul.sv -----
// ----------------------------------------------------------------------------
// msh_mul: digit-serial multiply by the Murmur constant
// Forms the low 64 bits of a * MUL_M, one operand digit per cycle, with a
// shifted copy of the constant and a running accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msh_mul
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    output logic             done,
    output logic [63:0]      product
);

    logic [63:0]                  x_reg;
    logic [63:0]                  m_reg;
    logic [63:0]                  acc_reg;
    logic [msh_pkg::DIGIT_CW-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [63:0]                  partial;

    // One digit times the shifted constant
    assign partial = {{(64 - msh_pkg::DIGIT_BITS){1'b0}}, x_reg[msh_pkg::DIGIT_BITS-1:0]}
                     * m_reg;

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == msh_pkg::DIGIT_CW'(msh_pkg::NUM_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand shift and accumulate
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= a;
            m_reg   <= msh_pkg::MUL_M;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= x_reg >> msh_pkg::DIGIT_BITS;
            m_reg   <= m_reg << msh_pkg::DIGIT_BITS;
            acc_reg <= acc_reg + partial;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

// ----- rtl/core/msh_mod.sv -----
// ----------------------------------------------------------------------------
// msh_mod: bit position of a hash modulo HASH_BITS
// Power-of-two sizes take the low bits directly; other sizes run a
// bit-serial remainder, one hash bit per cycle from the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module msh_mod
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [5:0]       pos
);

    localparam logic [6:0] HB   = 7'(msh_pkg::HASH_BITS);
    localparam logic [5:0] MASK = 6'(msh_pkg::HASH_BITS - 1);

    logic [63:0] shift_reg;
    logic [5:0]  rem_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  trial;
    logic [6:0]  rem_step;

    // One remainder step: r = (2r + bit) mod HASH_BITS
    always_comb
    begin
        trial    = {rem_reg, shift_reg[63]};
        rem_step = (trial >= HB) ? (trial - HB) : trial;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= '0;
                if (msh_pkg::HASH_POW2)
                begin
                    done_reg <= 1'b1;
                end
                else
                begin
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            shift_reg <= value;
            rem_reg   <= msh_pkg::HASH_POW2 ? (value[5:0] & MASK) : 6'd0;
        end
        else if (busy_reg)
        begin
            shift_reg <= shift_reg << 1;
            rem_reg   <= rem_step[5:0];
        end
    end

    assign done = done_reg;
    assign pos  = rem_reg;

endmodule

`default_nettype wire

// ----- rtl/core/multi_seed_hash_bit_signature.sv -----
// ----------------------------------------------------------------------------
// multi_seed_hash_bit_signature: multi-seed MurmurHash64A bit signature
// Hashes a name once per seed, keeps one running hash per seed, and on the
// last word sets bit (hash mod HASH_BITS) of a 64-bit signature per seed.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake               Content
//  s_*      in   s_tvalid / s_tready     name words, byte count, length, first
//  m_*      out  m_tvalid / m_tready     64-bit signature, one per name
//  APB      in   psel & penable & pwrite num_hashes at byte address 0
//
//  Products come one at a time from the shared multiplier. A word runs the
//  length product (first word only), the two key products (full block only)
//  and one mix product per seed for all MAX_SEEDS seeds; a last word of zero
//  bytes skips the mix products. The last word then finalizes
//  min(num_hashes, MAX_SEEDS) seeds, with a product and a remainder each, and
//  loads the output register.
//  Reset marks the running hashes invalid, so they read as zero, and sets num_hashes to 4.
//  A finished signature waits in the output register; the next word is
//  taken while it waits, and only a second signature stalls on m_tready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multi_seed_hash_bit_signature
#(
    parameter int MAX_SEEDS = msh_pkg::MAX_SEEDS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [79:0] s_tdata,   // name_word[63:0], byte_count[67:64],
                                        // name_length[79:68]
    input  wire logic [0:0]  s_tuser,   // first_word[0]
    input  wire logic        s_tlast,
    // Output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // signature[63:0]
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SEED_W = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;

    msh_pkg::state_t state_reg;
    msh_pkg::state_t state_next;

    // Configuration
    logic [3:0]  num_hashes_reg;
    logic [4:0]  nh_ext;
    logic [4:0]  n_eff;

    // Latched transaction
    logic [63:0] word_reg;
    logic [3:0]  count_reg;
    logic        first_reg;
    logic        last_reg;
    logic [11:0] len_reg;

    // Working values
    logic [63:0] lenm_reg;
    logic [63:0] k_reg;
    logic [63:0] f_reg;
    logic [63:0] sig_reg;
    logic [SEED_W-1:0] seed_reg;
    logic        launched_reg;

    // Running hash store
    logic [63:0] hash_reg  [MAX_SEEDS];
    logic [MAX_SEEDS-1:0] valid_reg;
    logic [63:0] hash_rd;
    logic [63:0] h_cur;
    logic        hash_we;
    logic [63:0] hash_wdata;

    // Output register
    logic        out_valid_reg;
    logic [63:0] out_data_reg;

    // Input field views
    logic [63:0] in_word;
    logic [3:0]  in_count;
    logic [11:0] in_len;
    logic [11:0] in_len_sat;
    logic        in_first;
    logic        in_full;
    logic [63:0] tail_mask;
    logic        accept;

    // Shared units
    logic        mul_start;
    logic [63:0] mul_a;
    logic        mul_done;
    logic [63:0] mul_p;
    logic        mod_start;
    logic        mod_done;
    logic [5:0]  mod_pos;

    // Sequencing conditions
    logic        has_data;
    logic        full_blk;
    logic        mix_step;
    logic        seed_last;
    logic        fin_last;
    logic        out_free;

    // ------------------------------------------------------------------------
    // Field decode
    // ------------------------------------------------------------------------
    assign in_word  = s_tdata[63:0];
    assign in_count = s_tdata[67:64];
    assign in_len   = s_tdata[79:68];
    assign in_first = s_tuser[0];
    assign in_full  = !s_tlast || (in_count >= msh_pkg::FULL_BYTES);
    assign accept   = s_tvalid && s_tready;

    assign in_len_sat = (17'(in_len) > 17'(msh_pkg::MAX_NAME_BYTES))
                        ? 12'(msh_pkg::MAX_NAME_BYTES) : in_len;

    // Keep only the bytes below the count for a tail word
    always_comb
    begin
        for (int b = 0; b < 8; b++)
        begin
            tail_mask[8*b +: 8] = (4'(b) < in_count) ? 8'hFF : 8'h00;
        end
    end

    // ------------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_hashes_reg <= msh_pkg::NUM_HASHES_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == msh_pkg::ADDR_NUM_HASHES))
        begin
            num_hashes_reg <= pwdata[3:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == msh_pkg::ADDR_NUM_HASHES) ? 32'(num_hashes_reg) : 32'd0;

    assign nh_ext = {1'b0, num_hashes_reg};
    assign n_eff  = (nh_ext > 5'(MAX_SEEDS)) ? 5'(MAX_SEEDS) : nh_ext;

    // ------------------------------------------------------------------------
    // Hash store read and current seed value
    // ------------------------------------------------------------------------
    assign hash_rd = valid_reg[seed_reg] ? hash_reg[seed_reg] : 64'd0;
    assign h_cur   = first_reg ? (64'(seed_reg) ^ lenm_reg) : hash_rd;

    assign has_data  = !last_reg || (count_reg != 4'd0);
    assign full_blk  = !last_reg || (count_reg >= msh_pkg::FULL_BYTES);
    assign mix_step  = (state_reg == msh_pkg::ST_MIX) && (has_data ? mul_done : 1'b1);
    assign seed_last = (seed_reg == SEED_W'(MAX_SEEDS - 1));
    assign fin_last  = (5'(seed_reg) == (n_eff - 5'd1));
    assign out_free  = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            msh_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (in_first)
                    begin
                        state_next = msh_pkg::ST_LEN;
                    end
                    else if (in_full)
                    begin
                        state_next = msh_pkg::ST_K1;
                    end
                    else
                    begin
                        state_next = msh_pkg::ST_MIX;
                    end
                end
            end
            msh_pkg::ST_LEN:
            begin
                if (mul_done)
                begin
                    state_next = full_blk ? msh_pkg::ST_K1 : msh_pkg::ST_MIX;
                end
            end
            msh_pkg::ST_K1:
            begin
                if (mul_done)
                begin
                    state_next = msh_pkg::ST_K2;
                end
            end
            msh_pkg::ST_K2:
            begin
                if (mul_done)
                begin
                    state_next = msh_pkg::ST_MIX;
                end
            end
            msh_pkg::ST_MIX:
            begin
                if (mix_step && seed_last)
                begin
                    if (!last_reg)
                    begin
                        state_next = msh_pkg::ST_IDLE;
                    end
                    else if (n_eff == 5'd0)
                    begin
                        state_next = msh_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = msh_pkg::ST_FIN;
                    end
                end
            end
            msh_pkg::ST_FIN:
            begin
                if (mul_done)
                begin
                    state_next = msh_pkg::ST_MOD;
                end
            end
            msh_pkg::ST_MOD:
            begin
                if (mod_done)
                begin
                    state_next = fin_last ? msh_pkg::ST_EMIT : msh_pkg::ST_FIN;
                end
            end
            msh_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = msh_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = msh_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msh_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer outputs: unit launches and operand select
    // ------------------------------------------------------------------------
    always_comb
    begin
        s_tready  = 1'b0;
        mul_start = 1'b0;
        mod_start = 1'b0;
        mul_a     = 64'd0;
        hash_we   = 1'b0;
        hash_wdata = mul_p;
        unique case (state_reg)
            msh_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            msh_pkg::ST_LEN:
            begin
                mul_start = !launched_reg;
                mul_a     = 64'(len_reg);
            end
            msh_pkg::ST_K1:
            begin
                mul_start = !launched_reg;
                mul_a     = word_reg;
            end
            msh_pkg::ST_K2:
            begin
                mul_start = !launched_reg;
                mul_a     = k_reg;
            end
            msh_pkg::ST_MIX:
            begin
                mul_start  = has_data && !launched_reg;
                mul_a      = h_cur ^ k_reg;
                hash_we    = mix_step;
                hash_wdata = has_data ? mul_p : h_cur;
            end
            msh_pkg::ST_FIN:
            begin
                mul_start = !launched_reg;
                mul_a     = hash_rd ^ (hash_rd >> msh_pkg::SHIFT_R);
            end
            msh_pkg::ST_MOD:
            begin
                mod_start = !launched_reg;
            end
            msh_pkg::ST_EMIT:
            begin
                s_tready = 1'b0;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            launched_reg  <= 1'b0;
            seed_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // A unit is running for the current state
            if (mul_start || mod_start)
            begin
                launched_reg <= 1'b1;
            end
            else if (mul_done || mod_done)
            begin
                launched_reg <= 1'b0;
            end

            // Seed walk for mixing and finalization
            if (accept)
            begin
                seed_reg <= '0;
            end
            else if (mix_step)
            begin
                seed_reg <= seed_last ? '0 : seed_reg + 1'b1;
            end
            else if ((state_reg == msh_pkg::ST_MOD) && mod_done && !fin_last)
            begin
                seed_reg <= seed_reg + 1'b1;
            end

            // Output register
            if ((state_reg == msh_pkg::ST_EMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg  <= in_word;
            count_reg <= in_count;
            first_reg <= in_first;
            last_reg  <= s_tlast;
            len_reg   <= in_len_sat;
            k_reg     <= in_word & tail_mask;
            sig_reg   <= 64'd0;
        end
        else
        begin
            if ((state_reg == msh_pkg::ST_LEN) && mul_done)
            begin
                lenm_reg <= mul_p;
            end
            if ((state_reg == msh_pkg::ST_K1) && mul_done)
            begin
                k_reg <= mul_p ^ (mul_p >> msh_pkg::SHIFT_R);
            end
            if ((state_reg == msh_pkg::ST_K2) && mul_done)
            begin
                k_reg <= mul_p;
            end
            if ((state_reg == msh_pkg::ST_FIN) && mul_done)
            begin
                f_reg <= mul_p ^ (mul_p >> msh_pkg::SHIFT_R);
            end
            if ((state_reg == msh_pkg::ST_MOD) && mod_done)
            begin
                sig_reg <= sig_reg | (64'd1 << mod_pos);
            end
        end

        if ((state_reg == msh_pkg::ST_EMIT) && out_free)
        begin
            out_data_reg <= sig_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Running hash store
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (hash_we)
        begin
            hash_reg[seed_reg] <= hash_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (hash_we)
        begin
            valid_reg[seed_reg] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Shared units
    // ------------------------------------------------------------------------
    msh_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .done    (mul_done),
        .product (mul_p)
    );

    msh_mod u_mod
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .value (f_reg),
        .done  (mod_done),
        .pos   (mod_pos)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // A product only returns for a launched multiply
    assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> launched_reg)
        else $error("multiplier result without a launch");

    // A remainder only returns while finalizing
    assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (state_reg == msh_pkg::ST_MOD))
        else $error("remainder result outside finalization");

    // One transaction at a time on the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while a word is in work");

    // With at least one seed applied the signature has a bit set
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == msh_pkg::ST_EMIT) && (n_eff != 5'd0)) |-> (sig_reg != 64'd0))
        else $error("empty signature with seeds applied");

    // Emitting loads the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == msh_pkg::ST_EMIT) && out_free) |=> m_tvalid)
        else $error("signature not presented after emit");
`endif

endmodule

`default_nettype wire
